// File: src/isrch_pkg.sv
// Shared widths and defaults for the interpolation search engine.
package isrch_pkg;

  localparam int IDX_W           = 10;               // table index field width
  localparam int VAL_W           = 32;               // table entry / key width
  localparam int PTR_W           = IDX_W + 2;        // signed range pointer, holds -1 .. 2**IDX_W
  localparam int PROD_W          = VAL_W + IDX_W;    // offset times span
  localparam int CNT_W           = $clog2(IDX_W);    // quotient bit counter
  localparam int DEF_TABLE_DEPTH = 1024;

endpackage

// File: src/interpolation_search_engine.sv
// Interpolation search engine top level: table RAM, probe sequencer and result strobe.
//
// A beat on the input side is accepted when start is high and busy is low. A write beat
// (in_cmd = 0) stores in_entry_value at in_entry_index and leaves busy low,
// so writes may stream one per cycle; an index beyond the table is dropped. A search beat
// (in_cmd = 1) raises busy and walks the range [in_lower_bound, in_upper_bound] (bounds
// beyond the table saturate to its last entry) until the key is found or ruled out, then
// pulses out_valid for exactly one cycle with out_found and out_position (zero when not
// found). There is no backpressure: capture the result in that cycle. A search ends when its
// range empties, when its last probe hits the key, or when the key falls outside the end
// values of the remaining range. A probe reads the low end and the high end through the
// single RAM read port and tests the bounds, then reads and compares the probe point; on a
// flat range (both ends equal) the probe point is the low end. An interpolated probe first
// waits on the offset unit, which captures the operands, forms the 32x10 product and then
// develops the ten quotient bits before its done strobe. The table has no reset: read only
// entries that have been written. Keep the table sorted ascending for meaningful results;
// an unsorted table still terminates.
module interpolation_search_engine #(
  parameter int TABLE_DEPTH = isrch_pkg::DEF_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [isrch_pkg::IDX_W-1:0] in_entry_index,
  input  logic signed [isrch_pkg::VAL_W-1:0] in_entry_value,
  input  logic signed [isrch_pkg::VAL_W-1:0] in_search_key,
  input  logic [isrch_pkg::IDX_W-1:0] in_lower_bound,
  input  logic [isrch_pkg::IDX_W-1:0] in_upper_bound,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [isrch_pkg::IDX_W-1:0] out_position
);
  import isrch_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  // Highest index reachable through the 10-bit fields and present in the table.
  localparam logic [IDX_W-1:0] MAX_IDX = (TABLE_DEPTH > 2**IDX_W) ?
                                         IDX_W'(2**IDX_W - 1) : IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,     // test range, read low end
    S_RD_HI,    // read high end, low end data arrives
    S_CHECK,    // high end data arrives, bound test, launch offset unit
    S_DIV,      // wait for the offset quotient
    S_RD_POS,   // read probe point
    S_CMP       // compare probe value with key, narrow range
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [IDX_W-1:0]          out_pos_r, out_pos_nxt;

  logic signed [VAL_W-1:0]   key_r, key_nxt;
  logic signed [PTR_W-1:0]   lo_r, lo_nxt;
  logic signed [PTR_W-1:0]   hi_r, hi_nxt;
  logic signed [VAL_W-1:0]   alo_r, alo_nxt;
  logic [IDX_W-1:0]          pos_r, pos_nxt;

  logic                      accept;
  logic                      wr_en;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [VAL_W-1:0]          rd_data;
  logic signed [VAL_W-1:0]   rd_val;
  logic [IDX_W-1:0]          lo_clamp;
  logic [IDX_W-1:0]          hi_clamp;

  logic signed [VAL_W:0]     diff_full;
  logic signed [VAL_W:0]     den_full;
  logic signed [PTR_W-1:0]   span_full;
  logic                      div_go;
  logic                      div_done;
  logic [IDX_W-1:0]          div_quot;

  assign accept = start && !busy;
  assign wr_en  = accept && !in_cmd && (in_entry_index <= MAX_IDX);
  assign rd_val = $signed(rd_data);

  assign lo_clamp = (in_lower_bound > MAX_IDX) ? MAX_IDX : in_lower_bound;
  assign hi_clamp = (in_upper_bound > MAX_IDX) ? MAX_IDX : in_upper_bound;

  // Offset operands: key - A[lo] is non-negative and A[hi] - A[lo] is positive when the unit runs.
  assign diff_full = {key_r[VAL_W-1], key_r} - {alo_r[VAL_W-1], alo_r};
  assign den_full  = {rd_val[VAL_W-1], rd_val} - {alo_r[VAL_W-1], alo_r};
  assign span_full = hi_r - lo_r;

  isrch_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  isrch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .numer (diff_full[VAL_W-1:0]),
    .span  (span_full[IDX_W-1:0]),
    .denom (den_full[VAL_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    alo_nxt       = alo_r;
    pos_nxt       = pos_r;
    rd_en         = 1'b0;
    rd_addr       = AW'(lo_r[IDX_W-1:0]);
    div_go        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd) begin
          key_nxt   = in_search_key;
          lo_nxt    = PTR_W'(lo_clamp);
          hi_nxt    = PTR_W'(hi_clamp);
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (lo_r > hi_r) begin
          // Range emptied: report a miss.
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(lo_r[IDX_W-1:0]);
          state_nxt = S_RD_HI;
        end
      end
      S_RD_HI: begin
        alo_nxt   = rd_val;
        rd_en     = 1'b1;
        rd_addr   = AW'(hi_r[IDX_W-1:0]);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if ((key_r < alo_r) || (key_r > rd_val)) begin
          // Key outside the values spanned by the range.
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          state_nxt     = S_IDLE;
        end else if (rd_val == alo_r) begin
          // Flat range: probe the low end, no division.
          pos_nxt   = lo_r[IDX_W-1:0];
          state_nxt = S_RD_POS;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          pos_nxt   = lo_r[IDX_W-1:0] + div_quot;
          state_nxt = S_RD_POS;
        end
      end
      S_RD_POS: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(pos_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_val == key_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          state_nxt     = S_IDLE;
        end else begin
          // Advance past the probe on the side that can still hold the key.
          if (rd_val < key_r) begin
            lo_nxt = PTR_W'(pos_r) + PTR_W'(1);
          end else begin
            hi_nxt = PTR_W'(pos_r) - PTR_W'(1);
          end
          state_nxt = S_LOOP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    key_r       <= key_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    alo_r       <= alo_nxt;
    pos_r       <= pos_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

  // The result beat only appears once the sequencer has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a search is still running");

  // A write beat never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd) |=> !out_valid)
    else $error("write beat produced a result");

  // A search beat takes the engine busy on the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd) |=> busy)
    else $error("search beat did not start the sequencer");

  // The offset unit only reports back while the sequencer waits for it.
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("offset quotient arrived outside its wait state");

endmodule

// File: src/isrch_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module isrch_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/isrch_div.sv
// Probe offset unit: a multiply step, then one restoring quotient bit per cycle.
module isrch_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [isrch_pkg::VAL_W-1:0] numer,
  input  logic [isrch_pkg::IDX_W-1:0] span,
  input  logic [isrch_pkg::VAL_W-1:0] denom,
  output logic                      done,
  output logic [isrch_pkg::IDX_W-1:0] quot
);
  import isrch_pkg::*;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_DIV
  } dstate_t;

  dstate_t             state_r, state_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VAL_W-1:0]    num_r, num_nxt;
  logic [VAL_W-1:0]    den_r, den_nxt;
  logic [IDX_W-1:0]    span_r, span_nxt;
  logic [PROD_W-1:0]   rem_r, rem_nxt;
  logic [IDX_W-1:0]    quot_r, quot_nxt;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   trial;
  logic                fits;

  // Quotient never exceeds span, so IDX_W bits cover it.
  assign prod  = num_r * span_r;
  assign trial = {{IDX_W{1'b0}}, den_r} << cnt_r;
  assign fits  = (rem_r >= trial);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    case (state_r)
      D_IDLE: begin
        if (go) begin
          num_nxt   = numer;
          den_nxt   = denom;
          span_nxt  = span;
          state_nxt = D_MUL;
        end
      end
      D_MUL: begin
        rem_nxt   = prod;
        quot_nxt  = '0;
        cnt_nxt   = CNT_W'(IDX_W - 1);
        state_nxt = D_DIV;
      end
      D_DIV: begin
        if (fits) begin
          rem_nxt = rem_r - trial;
        end
        quot_nxt = {quot_r[IDX_W-2:0], fits};
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: tb/sv/tb_interpolation_search_engine.sv
// Self-checking testbench for the interpolation search engine: table writes and searches.
module tb_interpolation_search_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import isrch_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int PROBE_CYCLES = 17;      // worst cost of one interpolated probe
  localparam int BEAT_SLACK = 40;        // sender gaps and handshake overhead per beat
  localparam int DRAIN_CYCLES = 40;      // quiet time after the last result
  localparam int TARGET_BEATS = 600;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam int VAL_MIN = -2147483647 - 1;
  localparam int VAL_MAX = 2147483647;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
    logic [VAL_W-1:0] search_key;
    logic [IDX_W-1:0] lower_bound;
    logic [IDX_W-1:0] upper_bound;
  } isrch_beat_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } lookup_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    in_cmd = CMD_WRITE;
  logic [IDX_W-1:0]        in_entry_index = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic signed [VAL_W-1:0] in_search_key = '0;
  logic [IDX_W-1:0]        in_lower_bound = '0;
  logic [IDX_W-1:0]        in_upper_bound = '0;
  logic                    out_valid;
  logic                    out_found;
  logic [IDX_W-1:0]        out_position;

  interpolation_search_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .in_search_key (in_search_key),
    .in_lower_bound(in_lower_bound),
    .in_upper_bound(in_upper_bound),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_position  (out_position)
  );

  // Stimulus side: beats waiting to be driven and the generator's view of the table,
  // used only to keep searches inside entries that have already been written.
  isrch_beat_t beats_pending[$];
  int          planned_vals[TABLE_DEPTH];
  bit          planned_set[TABLE_DEPTH];
  int          beats_total;
  int          beats_taken = 0;
  longint      cycle_budget = 0;
  longint      cycle_limit = 64'd100_000_000;
  longint      cycle_count = 0;

  // Prediction side: table contents as seen by accepted beats, and the search
  // results still owed by the block, oldest first.
  logic signed [VAL_W-1:0] entry_mem[TABLE_DEPTH];
  lookup_result_t          lookups_due[$];
  int                      fault_count = 0;

  isrch_beat_t cur_beat;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the inclusive range exactly as the engine does: probe at the interpolated
  // point (or the low end on a flat range), then narrow to one side of the probe.
  function automatic lookup_result_t interp_lookup(input logic [VAL_W-1:0] key_bits,
                                                   input int lo_in, input int hi_in);
    lookup_result_t res;
    longint key, lo, hi, alo, ahi, probe, aprobe;
    bit searching;
    res = '0;
    key = longint'($signed(key_bits));
    lo = lo_in;
    hi = hi_in;
    searching = 1'b1;
    while (searching && lo <= hi) begin
      alo = entry_mem[lo];
      ahi = entry_mem[hi];
      if (key < alo || key > ahi) begin
        searching = 1'b0;
      end else begin
        if (ahi == alo) probe = lo;
        else probe = lo + ((key - alo) * (hi - lo)) / (ahi - alo);
        if (probe < lo) probe = lo;
        if (probe > hi) probe = hi;
        aprobe = entry_mem[probe];
        if (aprobe == key) begin
          res.found = 1'b1;
          res.position = probe[IDX_W-1:0];
          searching = 1'b0;
        end else if (aprobe < key) begin
          lo = probe + 1;
        end else begin
          hi = probe - 1;
        end
      end
    end
    return res;
  endfunction

  // Update the table on a write beat; owe one result per search beat.
  function automatic void absorb_beat(input isrch_beat_t b);
    if (b.cmd == CMD_WRITE) begin
      entry_mem[b.entry_index] = b.entry_value;
    end else begin
      lookups_due.push_back(interp_lookup(b.search_key, int'(b.lower_bound),
                                          int'(b.upper_bound)));
    end
  endfunction

  // Fill the fields a write ignores with noise so they toggle freely.
  task automatic queue_write(input int idx, input int val);
    isrch_beat_t b;
    b.cmd = CMD_WRITE;
    b.entry_index = idx[IDX_W-1:0];
    b.entry_value = val;
    b.search_key = $urandom;
    b.lower_bound = IDX_W'($urandom);
    b.upper_bound = IDX_W'($urandom);
    beats_pending.push_back(b);
    planned_vals[idx] = val;
    planned_set[idx] = 1'b1;
    cycle_budget += BEAT_SLACK;
  endtask

  // Each probe drops at least one entry from the range, so the range length bounds the
  // probe count; budget the search for that many worst-case probes.
  task automatic queue_search(input int key, input int lo, input int hi);
    isrch_beat_t b;
    int span;
    b.cmd = CMD_SEARCH;
    b.entry_index = IDX_W'($urandom);
    b.entry_value = $urandom;
    b.search_key = key;
    b.lower_bound = lo[IDX_W-1:0];
    b.upper_bound = hi[IDX_W-1:0];
    beats_pending.push_back(b);
    span = (hi >= lo) ? hi - lo + 1 : 1;
    cycle_budget += BEAT_SLACK + 2 + PROBE_CYCLES * span;
  endtask

  // Mostly keys present in the range, then near misses, then anything at all.
  function automatic int pick_key(input int lo, input int hi);
    int idx, roll;
    idx = $urandom_range(hi, lo);
    roll = $urandom_range(0, 99);
    if (roll < 60) return planned_vals[idx];
    if (roll < 75) return planned_vals[idx] + 1;
    if (roll < 85) return planned_vals[idx] - 1;
    return int'($urandom);
  endfunction

  // Write a run of entries: ascending with a random stride (small strides give flat
  // stretches), or scrambled to exercise the unsorted case.
  task automatic fill_block(input int base, input int len, input bit scrambled);
    longint v;
    int stride_cap, k;
    case ($urandom_range(0, 3))
      0: stride_cap = 3;
      1: stride_cap = 1000;
      2: stride_cap = 1 << 20;
      default: stride_cap = 1 << 24;
    endcase
    if (len > 40) v = longint'(VAL_MIN) + $urandom_range(0, 1 << 30);
    else v = longint'(int'($urandom));
    for (k = 0; k < len; k++) begin
      if (scrambled) begin
        queue_write(base + k, int'($urandom));
      end else begin
        queue_write(base + k, int'(v));
        v += $urandom_range(0, stride_cap);
        if (v > VAL_MAX) v = VAL_MAX;
      end
    end
  endtask

  task automatic plan_directed();
    // Extremes of the value range plus a flat pair near the top of the table.
    queue_write(0, VAL_MIN);
    queue_write(1, -5);
    queue_write(2, 0);
    queue_write(3, 7);
    queue_write(4, VAL_MAX);
    queue_write(1023, VAL_MAX);
    queue_write(1022, 100);
    queue_write(1021, 100);
    queue_search(VAL_MIN, 0, 4);     // hit at the low end
    queue_search(VAL_MAX, 0, 4);     // hit at the high end
    queue_search(0, 0, 4);           // hit in the middle across the full value span
    queue_search(3, 0, 4);           // miss between entries
    queue_search(8, 0, 3);           // key above the range
    queue_search(VAL_MIN, 1, 4);     // key below the range
    queue_search(0, 4, 0);           // reversed bounds
    queue_search(100, 1021, 1022);   // flat range, hit
    queue_search(99, 1021, 1022);    // flat range, key below
    queue_search(VAL_MAX, 1022, 1023);
    queue_search(0, 2, 2);           // single entry
    // Break the order and search across it.
    queue_write(5, -100);
    queue_search(7, 3, 5);
    queue_search(-100, 0, 5);
  endtask

  task automatic plan_random();
    int roll, base, len, n, k, lo, hi, tmp;
    bit scrambled;
    while (beats_pending.size() < TARGET_BEATS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // Well-formed sequence: load a block, then search inside it.
        base = $urandom_range(0, TABLE_DEPTH - 1);
        scrambled = ($urandom_range(0, 99) < 15);
        if (!scrambled && $urandom_range(0, 99) < 10) len = $urandom_range(100, 300);
        else len = $urandom_range(2, 40);
        if (base + len > TABLE_DEPTH) len = TABLE_DEPTH - base;
        // Keep the last block from overshooting the beat count by much.
        if (len > TARGET_BEATS - beats_pending.size())
          len = TARGET_BEATS - beats_pending.size();
        if (len < 1) len = 1;
        fill_block(base, len, scrambled);
        n = $urandom_range(2, 6);
        for (k = 0; k < n; k++) begin
          lo = $urandom_range(base, base + len - 1);
          hi = $urandom_range(lo, base + len - 1);
          if ($urandom_range(0, 99) < 10) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          queue_search(pick_key(lo, hi), lo, hi);
        end
      end else if (roll < 65) begin
        // Stray write anywhere: noise that may break the order.
        queue_write($urandom_range(0, TABLE_DEPTH - 1), int'($urandom));
      end else begin
        // Search a written stretch that may span several blocks.
        lo = $urandom_range(0, TABLE_DEPTH - 1);
        if (planned_set[lo]) begin
          hi = lo;
          while (hi < TABLE_DEPTH - 1 && hi - lo < 60 && planned_set[hi + 1]) hi++;
          hi = $urandom_range(lo, hi);
          queue_search(pick_key(lo, hi), lo, hi);
        end
      end
    end
  endtask

  initial begin
    foreach (planned_set[i]) planned_set[i] = 1'b0;
    plan_directed();
    plan_random();
    beats_total = beats_pending.size();
    cycle_limit = 4 * cycle_budget + 50_000;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Hold until every beat is in and every owed result has come back, then drain.
    while (beats_taken != beats_total || lookups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && lookups_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Driver: present one beat at a time and keep start high until busy lets it in.
  // While start is low, idle at random except for a quiet stretch mid-run; gaps then
  // land on every cycle of a running search since the next beat may rise at any point.
  always @(posedge clk) begin : drive_beats
    bit hold_off;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_beat(cur_beat);
        beats_taken++;
      end
      if (!(start && busy)) begin
        hold_off = ($urandom_range(0, 99) < 19) && !(beats_taken >= 200 && beats_taken < 320);
        if (beats_pending.size() != 0 && !hold_off) begin
          cur_beat = beats_pending.pop_front();
          in_cmd <= cur_beat.cmd;
          in_entry_index <= cur_beat.entry_index;
          in_entry_value <= cur_beat.entry_value;
          in_search_key <= cur_beat.search_key;
          in_lower_bound <= cur_beat.lower_bound;
          in_upper_bound <= cur_beat.upper_bound;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobe carries one search result; match it against the oldest one owed.
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid) begin
      if (lookups_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: found=%0d position=%0d", out_found, out_position);
      end else begin
        want = lookups_due.pop_front();
        if (out_found !== want.found || out_position !== want.position) begin
          fault_count++;
          if (fault_count <= 10)
            $display("search result mismatch: expected found=%0d position=%0d, got %0d / %0d",
                     want.found, want.position, out_found, out_position);
        end
      end
    end
  end

  // Watchdog: the limit is several times the slowest legal run of the planned beats.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
